@@ sv/btmm_pkg.sv @@
package btmm_pkg;

  // operand and result widths
  localparam int unsigned MantW = 24;
  localparam int unsigned ProdW = 48;

  // truncated tree geometry
  localparam int unsigned TreeW     = 32;
  localparam int unsigned NumDigits = 8;

  // masks used in the truncated tree
  localparam logic [TreeW-1:0] LowMask11  = 32'h0000_07ff;
  localparam logic [TreeW-1:0] LowMask12  = 32'h0000_0fff;
  localparam logic [TreeW-1:0] Bit11      = 32'h0000_0800;
  localparam logic [TreeW-1:0] Bit10      = 32'h0000_0400;
  localparam logic [TreeW-1:0] TruncMask  = 32'h0000_7fff;
  localparam logic [ProdW-1:0] FixBit     = 48'h0000_0000_8000;

  typedef struct packed {
    logic [TreeW-1:0] pp;
    logic             neg;
  } booth_t;

  typedef struct packed {
    logic [TreeW-1:0] sum;
    logic [TreeW-1:0] carry;
  } csa_t;

  // 3:2 carry-save compressor over the tree width
  function automatic csa_t csa3(input logic [TreeW-1:0] p, input logic [TreeW-1:0] q,
                                input logic [TreeW-1:0] s);
    logic [TreeW-1:0] h;
    csa_t r;
    h       = p ^ q;
    r.sum   = h ^ s;
    r.carry = ((h & s) | (p & q)) << 1;
    return r;
  endfunction

endpackage

@@ sv/btmm_in_if.sv @@
interface btmm_in_if import btmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MantW-1:0] multiplicand;
  logic [MantW-1:0] multiplier;

  modport source(output valid, output multiplicand, output multiplier, input ready);
  modport sink(input valid, input multiplicand, input multiplier, output ready);
endinterface

@@ sv/btmm_out_if.sv @@
interface btmm_out_if import btmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ProdW-1:0] product;

  modport source(output valid, output product, input ready);
  modport sink(input valid, input product, output ready);
endinterface

@@ sv/booth_truncated_mantissa_multiplier_unit.sv @@
// channel    dir  payload                      handshake
// operands   in   multiplicand[23:0]           valid / ready
//                 multiplier[23:0]
// result     out  product[47:0]                valid / ready
//
// four register stages: booth digits and exact product, first two tree levels,
// last two tree levels and truncated add, bit 15 correction into the output register
// one item per cycle unless result back-pressure stalls the pipeline
// the deepest path is the 24x24 exact multiply in the first stage
// rst clears the stage valid bits only; the data registers carry no reset
// each stage holds while the next one is full and stalled, so nothing is lost or repeated
module booth_truncated_mantissa_multiplier_unit import btmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  btmm_in_if.sink     operands,
  btmm_out_if.source  result
);

  // radix-4 booth partial product for digit k of the low multiplier bits
  function automatic booth_t booth_digit(input logic [MantW-1:0] x, input logic [MantW-1:0] y,
                                         input int unsigned k);
    logic [TreeW-1:0] ys;
    logic [TreeW-1:0] v;
    logic [TreeW-1:0] one;
    logic [2:0]       trip;
    logic             isneg;
    booth_t           r;
    ys = TreeW'(y);
    if (k == 0) begin
      trip = {y[1:0], 1'b0};
    end else begin
      trip = 3'(ys >> (2 * k - 1));
    end
    v     = TreeW'(x) << (2 * k);
    one   = TreeW'(1) << (2 * k);
    if (trip inside {3'd3, 3'd4}) begin
      v = v + v;
    end
    isneg = trip inside {[3'd4:3'd6]};
    if (isneg) begin
      v = v ^ ~(one - TreeW'(1));
    end
    if (!(trip inside {[3'd1:3'd6]})) begin
      v = '0;
    end
    r.pp  = v;
    r.neg = isneg;
    return r;
  endfunction

  // stage ready chain
  logic s1_valid, s2_valid, s3_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4           = !result.valid || result.ready;
  assign rdy3           = !s3_valid || rdy4;
  assign rdy2           = !s2_valid || rdy3;
  assign rdy1           = !s1_valid || rdy2;
  assign operands.ready = rdy1;

  // stage 1: booth digits and exact product
  logic [TreeW-1:0]     s1_pp [NumDigits];
  logic [NumDigits-1:0] s1_neg;
  logic [ProdW-1:0]     s1_exact;
  booth_t               dig [NumDigits];

  always_comb begin
    for (int unsigned k = 0; k < NumDigits; k++) begin
      dig[k] = booth_digit(operands.multiplicand, operands.multiplier, k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operands.valid && rdy1) begin
      for (int unsigned k = 0; k < NumDigits; k++) begin
        s1_pp[k]  <= dig[k].pp;
        s1_neg[k] <= dig[k].neg;
      end
      s1_exact <= ProdW'(operands.multiplicand) * ProdW'(operands.multiplier);
    end
  end

  // stage 2: first two carry-save levels
  csa_t             l1a, l1b, l2a, l2b;
  logic [TreeW-1:0] top;
  logic [TreeW-1:0] neg5_word, neg6_word;
  csa_t             s2_a, s2_b;
  logic             s2_neg7;
  logic [ProdW-1:0] s2_exact;

  always_comb begin
    neg5_word = TreeW'(s1_neg[5]) << 10;
    neg6_word = TreeW'(s1_neg[6]) << 12;
    l1a       = csa3(s1_pp[1], s1_pp[2], s1_pp[3]);
    l1b       = csa3(s1_pp[4] & ~LowMask11, s1_pp[5] & ~LowMask12, s1_pp[6]);
    l1b.carry = l1b.carry | neg6_word | (s1_pp[5] & Bit11);
    top       = s1_pp[7] | ((s1_pp[5] & Bit10) + neg5_word);
    l2a       = csa3(s1_pp[0], l1a.sum, l1a.carry);
    l2b       = csa3(top, l1b.sum, l1b.carry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && rdy2) begin
      s2_a     <= l2a;
      s2_b     <= l2b;
      s2_neg7  <= s1_neg[7];
      s2_exact <= s1_exact;
    end
  end

  // stage 3: last two levels and truncated final add
  csa_t             l3, l4;
  logic [TreeW-1:0] hi, lo, tsum;
  logic             s3_fix;
  logic [ProdW-1:0] s3_exact;

  always_comb begin
    l3   = csa3(s2_a.carry, s2_b.sum, s2_b.carry);
    l4   = csa3(s2_a.sum, l3.sum, l3.carry);
    hi   = (l4.carry + (TreeW'(s2_neg7) << 14)) & ~TruncMask;
    lo   = l4.sum & ~TruncMask;
    tsum = lo + hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && rdy3) begin
      s3_fix   <= tsum[15] ^ s2_exact[15];
      s3_exact <= s2_exact;
    end
  end

  // stage 4: bit 15 correction into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdy4) begin
      result.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && rdy4) begin
      result.product <= s3_exact - (s3_fix ? FixBit : '0);
    end
  end

  // no item leaves right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // a stalled tree stage keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !rdy3) |=> (s2_valid && $stable(s2_a) && $stable(s2_b) && $stable(s2_exact)))
    else $error("stage 2 item lost under stall");

  // correction never touches the bits below 15
  a_low_bits: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && rdy4) |=> (result.product[14:0] == $past(s3_exact[14:0])))
    else $error("low product bits altered by correction");

endmodule

@@ bench/booth_truncated_mantissa_multiplier_unit_tb.sv @@
module booth_truncated_mantissa_multiplier_unit_tb import btmm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CalmFirst   = 1000;
  localparam int unsigned CalmLast    = 2000;
  localparam int unsigned IdlePercent = 20;

  // masks of the truncated tree
  localparam logic [31:0] KeepAbove10 = ~32'h0000_07ff;
  localparam logic [31:0] KeepAbove11 = ~32'h0000_0fff;
  localparam logic [31:0] TreeBit11   = 32'h0000_0800;
  localparam logic [31:0] TreeBit10   = 32'h0000_0400;
  localparam logic [31:0] KeepAbove14 = ~32'h0000_7fff;
  localparam logic [ProdW-1:0] Bit15Weight = 48'h0000_0000_8000;

  typedef struct packed {
    logic [MantW-1:0] multiplicand;
    logic [MantW-1:0] multiplier;
  } operand_pair_t;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] c;
  } cs_pair_t;

  logic clk;
  logic rst;

  btmm_in_if  operands ();
  btmm_out_if result ();

  booth_truncated_mantissa_multiplier_unit dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .result   (result)
  );

  operand_pair_t    pending_operands[$];
  logic [ProdW-1:0] expected_products[$];
  logic             in_taken;
  int unsigned      mismatch_count;
  int unsigned      stall_cycles;
  int unsigned      cycle_count;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one 3:2 compressor level over 32 bits
  function automatic cs_pair_t compress3(input logic [31:0] p, input logic [31:0] q,
                                         input logic [31:0] s);
    cs_pair_t r;
    r.s = p ^ q ^ s;
    r.c = (((p ^ q) & s) | (p & q)) << 1;
    return r;
  endfunction

  // partial product and negation bit of radix-4 digit k
  function automatic void booth_partial(input logic [MantW-1:0] x, input logic [MantW-1:0] y,
                                        input int k, output logic [31:0] pp,
                                        output logic [31:0] ng);
    logic [MantW:0] y_ext;
    logic [2:0]     trip;
    logic [31:0]    weight;
    logic [31:0]    v;
    logic           is_neg;
    y_ext  = {y, 1'b0};
    trip   = y_ext[2*k +: 3];
    weight = 32'd1 << (2 * k);
    v      = 32'(x) << (2 * k);
    if (trip == 3'd3 || trip == 3'd4) begin
      v = v << 1;
    end
    is_neg = (trip >= 3'd4 && trip <= 3'd6);
    if (is_neg) begin
      v = v ^ ~(weight - 32'd1);
    end
    if (trip == 3'd0 || trip == 3'd7) begin
      v = '0;
    end
    pp = v;
    ng = is_neg ? weight : '0;
  endfunction

  // exact product with bit 15 forced to the truncated tree's bit 15 by subtraction
  function automatic logic [ProdW-1:0] truncated_booth_product(input logic [MantW-1:0] x,
                                                               input logic [MantW-1:0] y);
    logic [31:0]      pp[8];
    logic [31:0]      ng[8];
    cs_pair_t         l1a, l1b, l2a, l2b, l3, l4;
    logic [31:0]      top, lo, hi, tsum;
    logic [ProdW-1:0] exact;
    for (int k = 0; k < 8; k++) begin
      booth_partial(x, y, k, pp[k], ng[k]);
    end
    l1a   = compress3(pp[1], pp[2], pp[3]);
    l1b   = compress3(pp[4] & KeepAbove10, pp[5] & KeepAbove11, pp[6]);
    l1b.c = l1b.c | ng[6] | (pp[5] & TreeBit11);
    top   = pp[7] | ((pp[5] & TreeBit10) + ng[5]);
    l2a   = compress3(pp[0], l1a.s, l1a.c);
    l2b   = compress3(top, l1b.s, l1b.c);
    l3    = compress3(l2a.c, l2b.s, l2b.c);
    l4    = compress3(l2a.s, l3.s, l3.c);
    hi    = (l4.c + ng[7]) & KeepAbove14;
    lo    = l4.s & KeepAbove14;
    tsum  = lo + hi;
    exact = ProdW'(x) * ProdW'(y);
    if (tsum[15] != exact[15]) begin
      exact = exact - Bit15Weight;
    end
    return exact;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t pr;
    logic [15:0]   low_pattern;
    pr.multiplicand = MantW'($urandom);
    pr.multiplier   = MantW'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        pr.multiplicand = MantW'($urandom_range(0, 1023));
        pr.multiplier   = MantW'($urandom_range(0, 1023));
      end
      6: begin
        if ($urandom_range(0, 1) == 0) pr.multiplicand = MantW'($urandom_range(0, 255));
        else pr.multiplier = MantW'($urandom_range(0, 255));
      end
      7: begin
        case ($urandom_range(0, 5))
          0: low_pattern = 16'hffff;
          1: low_pattern = 16'h0000;
          2: low_pattern = 16'haaaa;
          3: low_pattern = 16'h5555;
          4: low_pattern = 16'h8000;
          default: low_pattern = 16'h7fff;
        endcase
        pr.multiplier[15:0] = low_pattern;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: pr.multiplicand = '0;
          1: pr.multiplicand = MantW'(1);
          2: pr.multiplicand = '1;
          default: pr.multiplicand = 24'h80_0000;
        endcase
      end
      9: begin
        pr.multiplicand[MantW-1] = 1'b1;
        pr.multiplier[MantW-1]   = 1'b1;
      end
      default: begin
      end
    endcase
    return pr;
  endfunction

  // operand driver
  always @(negedge clk) begin
    if (rst) begin
      operands.valid <= 1'b0;
    end else if (!operands.valid || in_taken) begin
      if (pending_operands.size() != 0 &&
          ((cycle_count >= CalmFirst && cycle_count < CalmLast) ||
           $urandom_range(0, 99) >= IdlePercent)) begin
        operands.valid        <= 1'b1;
        operands.multiplicand <= pending_operands[0].multiplicand;
        operands.multiplier   <= pending_operands[0].multiplier;
        void'(pending_operands.pop_front());
      end else begin
        operands.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= (cycle_count >= CalmFirst && cycle_count < CalmLast) ||
                      $urandom_range(0, 99) >= IdlePercent;
    end
  end

  // monitor: predict on operand items, check product items
  always @(posedge clk) begin
    if (rst) begin
      in_taken     <= 1'b0;
      stall_cycles <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      in_taken    <= operands.valid && operands.ready;
      if (operands.valid && operands.ready) begin
        expected_products.push_back(
          truncated_booth_product(operands.multiplicand, operands.multiplier));
      end
      if (result.valid && result.ready) begin
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected product item %h", $realtime, result.product);
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (result.product !== expected_products[0]) begin
            $display("%0t: product expected %h actual %h", $realtime,
                     expected_products[0], result.product);
            mismatch_count <= mismatch_count + 1;
          end
          void'(expected_products.pop_front());
        end
      end
      if ((operands.valid && operands.ready) || (result.valid && result.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // watchdog
  initial begin
    wait (stall_cycles >= StallLimit);
    $display("[booth_truncated_mantissa_multiplier_unit] ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin
    operand_pair_t directed[25];
    rst                   = 1'b1;
    operands.valid        = 1'b0;
    operands.multiplicand = '0;
    operands.multiplier   = '0;
    result.ready          = 1'b0;
    in_taken              = 1'b0;
    mismatch_count        = 0;
    stall_cycles          = 0;
    cycle_count           = 0;

    // extremes, bit patterns, recoding edge patterns, tiny products for the borrow case
    directed = '{
      '{24'h00_0000, 24'h00_0000}, '{24'hff_ffff, 24'hff_ffff}, '{24'hff_ffff, 24'h00_0000},
      '{24'h00_0000, 24'hff_ffff}, '{24'h00_0001, 24'h00_0001}, '{24'h00_0001, 24'hff_ffff},
      '{24'hff_ffff, 24'h00_0001}, '{24'h80_0000, 24'h80_0000}, '{24'h80_0000, 24'hff_ffff},
      '{24'haa_aaaa, 24'h55_5555}, '{24'h55_5555, 24'haa_aaaa}, '{24'hff_ffff, 24'h00_ffff},
      '{24'hff_ffff, 24'hff_0000}, '{24'hff_ffff, 24'h00_8000}, '{24'hab_cdef, 24'h00_7fff},
      '{24'hc0_0000, 24'h00_aaaa}, '{24'h12_3456, 24'h00_5555}, '{24'h00_0003, 24'h00_0005},
      '{24'h00_0007, 24'h00_001f}, '{24'h00_01ff, 24'h00_0003}, '{24'h00_0080, 24'h00_0080},
      '{24'h00_00ff, 24'h00_00ff}, '{24'h00_7fff, 24'h00_0001}, '{24'h00_0001, 24'h00_7fff},
      '{24'h00_4000, 24'h00_0002}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) pending_operands.push_back(directed[i]);

    // hold the sender until every outstanding product has come back
    while (pending_operands.size() != 0 || operands.valid) @(posedge clk);
    while (expected_products.size() != 0) @(posedge clk);

    for (int n = 0; n < RandomItems; n++) begin
      pending_operands.push_back(random_pair());
    end

    while (pending_operands.size() != 0 || operands.valid) @(posedge clk);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_products.size() == 0) begin
      $display("[booth_truncated_mantissa_multiplier_unit] OK");
    end else begin
      $display("[booth_truncated_mantissa_multiplier_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/btmm_pkg.sv
sv/btmm_in_if.sv
sv/btmm_out_if.sv
sv/booth_truncated_mantissa_multiplier_unit.sv
bench/booth_truncated_mantissa_multiplier_unit_tb.sv
